@@ hdl/rla_pkg.sv @@
// shared types and constants for the rgb levels adjust block
package rla_pkg;

    // pixel layout
    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;

    // long division steps retired per divider pipeline stage
    localparam int DIV_STEPS = 4;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MARK_LOW   = 3'd0,
        CFG_MARK_MID   = 3'd1,
        CFG_MARK_HIGH  = 3'd2,
        CFG_RANGE_LOW  = 3'd3,
        CFG_RANGE_HIGH = 3'd4
    } cfg_idx_t;

    typedef logic [CH_W-1:0] chan_t;
    typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

    // configuration register set
    typedef struct packed {
        chan_t mark_low;
        chan_t mark_mid;
        chan_t mark_high;
        chan_t range_low;
        chan_t range_high;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mark_low:   8'd0,
        mark_mid:   8'd128,
        mark_high:  8'd255,
        range_low:  8'd0,
        range_high: 8'd255
    };

    // which part of the levels curve a channel falls on
    typedef enum logic [2:0] {
        SEG_MID  = 3'd0,
        SEG_ZERO = 3'd1,
        SEG_MAX  = 3'd2,
        SEG_LOW  = 3'd3,
        SEG_HIGH = 3'd4
    } seg_t;

    typedef seg_t [NUM_CH-1:0] seg_vec_t;

endpackage

@@ hdl/rla_level_front.sv @@
// front stage: classify each channel and form the division operands
module rla_level_front #(
    parameter int MAX_LEVEL = 255,
    parameter int MID_LEVEL = 128,
    parameter int NUM_W     = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  rla_pkg::cfg_t                                 cfg,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  rla_pkg::pix_t                                 in_pix,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [rla_pkg::NUM_CH-1:0][NUM_W-1:0]         out_num,
    output logic [rla_pkg::NUM_CH-1:0][rla_pkg::CH_W-1:0] out_den,
    output rla_pkg::seg_vec_t                             out_segs
);
    import rla_pkg::*;

    localparam int K_SGN = MAX_LEVEL + 1 - MID_LEVEL;
    localparam int K_MAG = (K_SGN < 0) ? -K_SGN : K_SGN;

    logic                              valid_reg;
    logic [NUM_CH-1:0][NUM_W-1:0]      num_reg, num_next;
    logic [NUM_CH-1:0][CH_W-1:0]       den_reg, den_next;
    seg_vec_t                          segs_reg, segs_next;

    // segment tests in priority order, operands for the linear parts
    always_comb begin
        for (int l = 0; l < NUM_CH; l++) begin
            num_next[l]  = '0;
            den_next[l]  = CH_W'(1);
            if (in_pix[l] == cfg.mark_mid) begin
                segs_next[l] = SEG_MID;
            end else if (in_pix[l] <= cfg.mark_low) begin
                segs_next[l] = SEG_ZERO;
            end else if (in_pix[l] >= cfg.mark_high) begin
                segs_next[l] = SEG_MAX;
            end else if (in_pix[l] < cfg.mark_mid) begin
                segs_next[l] = SEG_LOW;
                num_next[l]  = NUM_W'(MID_LEVEL) * NUM_W'(in_pix[l] - cfg.mark_low);
                den_next[l]  = cfg.mark_mid - cfg.mark_low;
            end else begin
                segs_next[l] = SEG_HIGH;
                num_next[l]  = NUM_W'(K_MAG) * NUM_W'(in_pix[l] - cfg.mark_mid);
                den_next[l]  = cfg.mark_high - cfg.mark_mid;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            segs_reg <= segs_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_segs  = segs_reg;

    // a linear segment never leaves with a zero divisor
    for (genvar l = 0; l < NUM_CH; l++) begin : g_chk
        a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
            out_valid && (out_segs[l] == SEG_LOW || out_segs[l] == SEG_HIGH)
            |-> out_den[l] != '0)
            else $error("linear segment with zero divisor");
    end

endmodule

@@ hdl/rla_div_pipe.sv @@
// pipelined unsigned restoring divider, several lanes sharing one flow control
module rla_div_pipe #(
    parameter int LANES  = 3,
    parameter int NUM_W  = 16,
    parameter int DEN_W  = 8,
    parameter int SIDE_W = 1,
    parameter int STEP_N = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [LANES-1:0][NUM_W-1:0]       in_num,
    input  logic [LANES-1:0][DEN_W-1:0]       in_den,
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [LANES-1:0][NUM_W-1:0]       out_quo,
    output logic [SIDE_W-1:0]                 out_side
);
    localparam int NSTG = (NUM_W + STEP_N - 1) / STEP_N;

    // view of each stage boundary, index 0 is the input
    logic [NSTG:0]                             st_vld;
    logic [NSTG:0]                             rdy;
    logic [NSTG:0][LANES-1:0][NUM_W-1:0]       st_wq;
    logic [NSTG:0][LANES-1:0][DEN_W-1:0]       st_rem;
    logic [NSTG:0][LANES-1:0][DEN_W-1:0]       st_den;
    logic [NSTG:0][SIDE_W-1:0]                 st_side;

    assign st_vld[0]  = in_valid;
    assign st_wq[0]   = in_num;
    assign st_rem[0]  = '0;
    assign st_den[0]  = in_den;
    assign st_side[0] = in_side;
    assign rdy[NSTG]  = out_ready;
    assign in_ready   = rdy[0];

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        logic                          vld_reg;
        logic [LANES-1:0][NUM_W-1:0]   wq_reg, wq_next;
        logic [LANES-1:0][DEN_W-1:0]   rem_reg, rem_next;
        logic [LANES-1:0][DEN_W-1:0]   den_reg;
        logic [SIDE_W-1:0]             side_reg;

        // numerator bits shift out at the top, quotient bits shift in at the bottom
        always_comb begin
            logic [DEN_W:0] trial;
            trial    = '0;
            wq_next  = st_wq[k];
            rem_next = st_rem[k];
            for (int l = 0; l < LANES; l++) begin
                for (int i = 0; i < STEP_N; i++) begin
                    if (k * STEP_N + i < NUM_W) begin
                        trial = {rem_next[l], wq_next[l][NUM_W-1]};
                        if (trial >= {1'b0, st_den[k][l]}) begin
                            trial      = trial - {1'b0, st_den[k][l]};
                            wq_next[l] = {wq_next[l][NUM_W-2:0], 1'b1};
                        end else begin
                            wq_next[l] = {wq_next[l][NUM_W-2:0], 1'b0};
                        end
                        rem_next[l] = trial[DEN_W-1:0];
                    end
                end
            end
        end

        assign rdy[k] = !vld_reg || rdy[k+1];

        // stage valid
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg <= st_vld[k];
            end
        end

        // stage payload
        always_ff @(posedge aclk) begin
            if (rdy[k] && st_vld[k]) begin
                wq_reg   <= wq_next;
                rem_reg  <= rem_next;
                den_reg  <= st_den[k];
                side_reg <= st_side[k];
            end
        end

        assign st_vld[k+1]  = vld_reg;
        assign st_wq[k+1]   = wq_reg;
        assign st_rem[k+1]  = rem_reg;
        assign st_den[k+1]  = den_reg;
        assign st_side[k+1] = side_reg;
    end

    assign out_valid = st_vld[NSTG];
    assign out_quo   = st_wq[NSTG];
    assign out_side  = st_side[NSTG];

    // final remainder stays below the divisor for a nonzero divisor
    for (genvar l = 0; l < LANES; l++) begin : g_chk
        a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
            st_vld[NSTG] && st_den[NSTG][l] != '0 |-> st_rem[NSTG][l] < st_den[NSTG][l])
            else $error("divider remainder not below divisor");
    end

endmodule

@@ hdl/rla_scale_mid.sv @@
// middle stage: levelled value per channel, times the output span magnitude
module rla_scale_mid #(
    parameter int MAX_LEVEL = 255,
    parameter int MID_LEVEL = 128,
    parameter int NUM_W     = 16,
    parameter int LVL_W     = 8
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  rla_pkg::cfg_t                                       cfg,
    input  logic                                                in_valid,
    output logic                                                in_ready,
    input  logic [rla_pkg::NUM_CH-1:0][NUM_W-1:0]               in_quo,
    input  rla_pkg::seg_vec_t                                   in_segs,
    output logic                                                out_valid,
    input  logic                                                out_ready,
    output logic [rla_pkg::NUM_CH-1:0][rla_pkg::CH_W+LVL_W-1:0] out_prod,
    output logic                                                out_neg
);
    import rla_pkg::*;

    localparam int  PROD_W = CH_W + LVL_W;
    localparam bit  K_NEG  = (MAX_LEVEL + 1 - MID_LEVEL) < 0;

    logic                             valid_reg;
    logic [NUM_CH-1:0][PROD_W-1:0]    prod_reg, prod_next;
    logic                             neg_reg;
    logic [NUM_CH-1:0][LVL_W-1:0]     lvl;
    logic [CH_W:0]                    span_diff;
    logic                             span_neg;
    logic [CH_W-1:0]                  span_mag;

    // signed output span split into sign and magnitude
    assign span_diff = {1'b0, cfg.range_high} - {1'b0, cfg.range_low};
    assign span_neg  = span_diff[CH_W];
    assign span_mag  = span_neg ? CH_W'(-span_diff) : span_diff[CH_W-1:0];

    // levelled value per channel
    always_comb begin
        for (int l = 0; l < NUM_CH; l++) begin
            case (in_segs[l])
                SEG_MID:  lvl[l] = LVL_W'(MID_LEVEL);
                SEG_ZERO: lvl[l] = '0;
                SEG_MAX:  lvl[l] = LVL_W'(MAX_LEVEL);
                SEG_LOW:  lvl[l] = in_quo[l][LVL_W-1:0];
                SEG_HIGH: begin
                    if (K_NEG) begin
                        lvl[l] = LVL_W'(MID_LEVEL) - in_quo[l][LVL_W-1:0];
                    end else begin
                        lvl[l] = in_quo[l][LVL_W-1:0] + LVL_W'(MID_LEVEL);
                    end
                end
                default:  lvl[l] = '0;
            endcase
            prod_next[l] = PROD_W'(span_mag) * PROD_W'(lvl[l]);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
            neg_reg  <= span_neg;
        end
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;
    assign out_neg   = neg_reg;

    // the lower segment quotient always stays below the mid level
    for (genvar l = 0; l < NUM_CH; l++) begin : g_chk
        a_low_quo: assert property (@(posedge aclk) disable iff (!aresetn)
            in_valid && in_segs[l] == SEG_LOW |-> in_quo[l] < NUM_W'(MID_LEVEL))
            else $error("lower segment quotient out of range");
    end

endmodule

@@ hdl/rla_out_stage.sv @@
// output stages: divide by the full level, apply span sign, add range offset, saturate
module rla_out_stage #(
    parameter int MAX_LEVEL = 255,
    parameter int QUO_W     = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rla_pkg::cfg_t                         cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [rla_pkg::NUM_CH-1:0][QUO_W-1:0] in_prod,
    input  logic                                  in_neg,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output rla_pkg::pix_t                         out_pix
);
    import rla_pkg::*;

    localparam int R_W = QUO_W + 2;

    // reciprocal of the full level, exact for every numerator below 2**QUO_W
    localparam int     RCP_SH  = QUO_W + $clog2(MAX_LEVEL);
    localparam int     RCP_W   = QUO_W + 2;
    localparam int     MUL_W   = QUO_W + RCP_W;
    localparam longint RCP_VAL = ((longint'(1) << RCP_SH) + longint'(MAX_LEVEL) - 1)
                                 / longint'(MAX_LEVEL);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);

    logic                          div_valid_reg;
    logic [NUM_CH-1:0][QUO_W-1:0]  quo_reg, quo_next;
    logic                          neg_reg;
    logic [NUM_CH-1:0][MUL_W-1:0]  mul;
    logic                          pix_ready;
    logic                          valid_reg;
    pix_t                          pix_reg, pix_next;
    logic [NUM_CH-1:0][R_W-1:0]    res;

    // quotient by the full level as a multiply and shift
    always_comb begin
        for (int l = 0; l < NUM_CH; l++) begin
            mul[l]      = {{RCP_W{1'b0}}, in_prod[l]} * {{QUO_W{1'b0}}, RCP};
            quo_next[l] = QUO_W'(mul[l] >> RCP_SH);
        end
    end

    assign in_ready = !div_valid_reg || pix_ready;

    // quotient stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg <= 1'b0;
        end else if (in_ready) begin
            div_valid_reg <= in_valid;
        end
    end

    // quotient stage payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            quo_reg <= quo_next;
            neg_reg <= in_neg;
        end
    end

    // offset and clamp per channel
    always_comb begin
        for (int l = 0; l < NUM_CH; l++) begin
            if (neg_reg) begin
                res[l] = R_W'(cfg.range_low) - R_W'(quo_reg[l]);
            end else begin
                res[l] = R_W'(cfg.range_low) + R_W'(quo_reg[l]);
            end
            if (res[l][R_W-1]) begin
                pix_next[l] = '0;
            end else if (|res[l][R_W-2:CH_W]) begin
                pix_next[l] = '1;
            end else begin
                pix_next[l] = res[l][CH_W-1:0];
            end
        end
    end

    assign pix_ready = !valid_reg || out_ready;

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pix_ready) begin
            valid_reg <= div_valid_reg;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (pix_ready && div_valid_reg) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

@@ hdl/rgb_levels_adjust.sv @@
// top level of the rgb levels adjust block
//
//  port group   dir  width  contents
//  s_axis_*     in   24     source pixel item
//  m_axis_*     out  24     levelled pixel item
//  cfg_wr_*     in   3/8    register write, no read-back
//
//  one pixel item per clock sustained while m_tready is high; the path runs through the input
//  register, the curve long division pipeline (4 quotient bits per stage over an N1 bit
//  numerator), the scale register, the reciprocal multiply register and the output register,
//  N1 = CH_W + bits(max(MID_LEVEL, |MAX_LEVEL+1-MID_LEVEL|)).
//  reset is synchronous and active low; it empties every stage and loads the
//  register defaults. every stage holds its item while the one after it is
//  full and stalled, so a stall on m_tready loses and repeats nothing.
module rgb_levels_adjust #(
    parameter int MAX_LEVEL = 255,
    parameter int MID_LEVEL = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write port
    input  logic                            cfg_wr_en,
    input  logic [rla_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [rla_pkg::CH_W-1:0]        cfg_wr_data,
    // source pixel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // red_in, green_in, blue_in
    // levelled pixel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata    // red_out, green_out, blue_out
);
    import rla_pkg::*;

    localparam int K_SGN   = MAX_LEVEL + 1 - MID_LEVEL;
    localparam int K_MAG   = (K_SGN < 0) ? -K_SGN : K_SGN;
    localparam int MUL_TOP = (MID_LEVEL > K_MAG) ? MID_LEVEL : K_MAG;
    localparam int N1_W    = $clog2(MUL_TOP + 1) + CH_W;
    localparam int LVL_TOP = (MAX_LEVEL > MID_LEVEL) ? MAX_LEVEL : MID_LEVEL;
    localparam int LVL_W   = $clog2(LVL_TOP + 1);
    localparam int N2_W    = CH_W + LVL_W;
    localparam int SEG_W   = $bits(seg_vec_t);

    cfg_t cfg_reg;

    logic                              fr_valid, fr_ready;
    logic [NUM_CH-1:0][N1_W-1:0]       fr_num;
    logic [NUM_CH-1:0][CH_W-1:0]       fr_den;
    seg_vec_t                          fr_segs;

    logic                              d1_valid, d1_ready;
    logic [NUM_CH-1:0][N1_W-1:0]       d1_quo;
    logic [SEG_W-1:0]                  d1_side;
    seg_vec_t                          d1_segs;

    logic                              sc_valid, sc_ready;
    logic [NUM_CH-1:0][N2_W-1:0]       sc_prod;
    logic                              sc_neg;

    pix_t                              out_pix;

    // configuration registers, writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_MARK_LOW:   cfg_reg.mark_low   <= cfg_wr_data;
                CFG_MARK_MID:   cfg_reg.mark_mid   <= cfg_wr_data;
                CFG_MARK_HIGH:  cfg_reg.mark_high  <= cfg_wr_data;
                CFG_RANGE_LOW:  cfg_reg.range_low  <= cfg_wr_data;
                CFG_RANGE_HIGH: cfg_reg.range_high <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // segment select and division operands
    rla_level_front #(
        .MAX_LEVEL (MAX_LEVEL),
        .MID_LEVEL (MID_LEVEL),
        .NUM_W     (N1_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (pix_t'(s_tdata)),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_num   (fr_num),
        .out_den   (fr_den),
        .out_segs  (fr_segs)
    );

    // curve division by the mark distance
    rla_div_pipe #(
        .LANES  (NUM_CH),
        .NUM_W  (N1_W),
        .DEN_W  (CH_W),
        .SIDE_W (SEG_W),
        .STEP_N (DIV_STEPS)
    ) u_div_curve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_num    (fr_num),
        .in_den    (fr_den),
        .in_side   (SEG_W'(fr_segs)),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .out_quo   (d1_quo),
        .out_side  (d1_side)
    );

    assign d1_segs = seg_vec_t'(d1_side);

    // levelled value times span
    rla_scale_mid #(
        .MAX_LEVEL (MAX_LEVEL),
        .MID_LEVEL (MID_LEVEL),
        .NUM_W     (N1_W),
        .LVL_W     (LVL_W)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (d1_valid),
        .in_ready  (d1_ready),
        .in_quo    (d1_quo),
        .in_segs   (d1_segs),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_prod  (sc_prod),
        .out_neg   (sc_neg)
    );

    // rescale by the full level, offset, clamp and output register
    rla_out_stage #(
        .MAX_LEVEL (MAX_LEVEL),
        .QUO_W     (N2_W)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (sc_valid),
        .in_ready  (sc_ready),
        .in_prod   (sc_prod),
        .in_neg    (sc_neg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (out_pix)
    );

    assign m_tdata = out_pix;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // with the sink ready every stage moves, so the source side is ready too
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output sink is ready");

    // a mid mark write lands in the register
    a_cfg_mid_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && cfg_wr_index == CFG_MARK_MID |=> cfg_reg.mark_mid == $past(cfg_wr_data))
        else $error("mid mark write lost");

endmodule

@@ verif/rgb_levels_adjust_tb.sv @@
// self-checking testbench for the rgb levels adjust block
`timescale 1ns / 1ps

module rgb_levels_adjust_tb;
    import rla_pkg::*;

    localparam int MAX_LEVEL      = 255;
    localparam int MID_LEVEL      = 128;
    localparam int DUT_LATENCY    = 8;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 170;
    localparam int PRESSURE_ITEMS = 80;
    localparam int TIMEOUT_NS     = 5_000_000;

    // register indexes past the end of the list, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_MID = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI  = 3'd7;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    chan_t                cfg_wr_data  = '0;
    logic                 s_tvalid     = 1'b0;
    logic                 s_tready;
    pix_t                 s_tdata      = '0;  // red_in, green_in, blue_in
    logic                 m_tvalid;
    logic                 m_tready     = 1'b0;
    pix_t                 m_tdata;            // red_out, green_out, blue_out

    // levels settings as the block should hold them
    cfg_t lvl_cfg = '{mark_low: 8'd0, mark_mid: 8'd128, mark_high: 8'd255,
                      range_low: 8'd0, range_high: 8'd255};

    pix_t  pending_q[$];   // pixels waiting to be offered
    pix_t  levelled_q[$];  // levelled pixels still to come out
    int    err_cnt        = 0;
    int    src_idle_pct   = 0;
    int    sink_stall_pct = 0;
    logic  hold_arm       = 1'b0;
    logic  hold_off       = 1'b0;
    logic  hold_done      = 1'b0;
    string chan_names[3]  = '{"red", "green", "blue"};

    rgb_levels_adjust #(
        .MAX_LEVEL (MAX_LEVEL),
        .MID_LEVEL (MID_LEVEL)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // levels curve of one channel
    function automatic int level_value(chan_t c);
        int ci, lo, mid, hi;
        ci  = c;
        lo  = lvl_cfg.mark_low;
        mid = lvl_cfg.mark_mid;
        hi  = lvl_cfg.mark_high;
        if (ci == mid)
            return MID_LEVEL;
        if (ci <= lo)
            return 0;
        if (ci >= hi)
            return MAX_LEVEL;
        if (ci < mid)
            return (MID_LEVEL * (ci - lo)) / (mid - lo);
        return ((MAX_LEVEL + 1 - MID_LEVEL) * (ci - mid)) / (hi - mid) + MID_LEVEL;
    endfunction

    // levels curve then output range, saturated to 8 bits
    function automatic chan_t adjust_value(chan_t c);
        int lvl, span, r;
        lvl  = level_value(c);
        span = int'(lvl_cfg.range_high) - int'(lvl_cfg.range_low);
        r    = (span * lvl) / MAX_LEVEL + int'(lvl_cfg.range_low);
        if (r < 0)
            r = 0;
        if (r > 255)
            r = 255;
        return r[7:0];
    endfunction

    function automatic pix_t level_pixel(pix_t p);
        pix_t q;
        for (int ch = 0; ch < NUM_CH; ch++)
            q[ch] = adjust_value(p[ch]);
        return q;
    endfunction

    // random channel, biased toward the marks and the extremes
    function automatic chan_t pick_channel();
        chan_t c;
        case ($urandom_range(9))
            6: c = chan_t'(lvl_cfg.mark_low + $urandom_range(4) - 2);
            7: c = chan_t'(lvl_cfg.mark_mid + $urandom_range(4) - 2);
            8: c = chan_t'(lvl_cfg.mark_high + $urandom_range(4) - 2);
            9: c = $urandom_range(1) ? 8'd255 : 8'd0;
            default: c = chan_t'($urandom_range(255));
        endcase
        return c;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_cnt++;
    endtask

    // source side: offer pending pixels, hold each until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                levelled_q.push_back(level_pixel(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: check each item against the oldest levelled pixel
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (levelled_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item %h", m_tdata));
                end else begin
                    pix_t want;
                    want = levelled_q.pop_front();
                    for (int ch = 0; ch < NUM_CH; ch++)
                        if (m_tdata[ch] !== want[ch])
                            report_mismatch($sformatf("%s got %0d want %0d",
                                chan_names[ch], m_tdata[ch], want[ch]));
                end
            end
            m_tready <= hold_off ? 1'b0 : ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // long receiver hold-off, counted here once armed
    initial begin : rx_hold
        int hold_cnt;
        do @(posedge aclk); while (!hold_arm);
        hold_off <= 1'b1;
        for (hold_cnt = 0; hold_cnt < RX_HOLD_CYCLES; hold_cnt++)
            @(posedge aclk);
        hold_off  <= 1'b0;
        hold_done <= 1'b1;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("rgb_levels_adjust test failed");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, chan_t val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MARK_LOW:   lvl_cfg.mark_low   = val;
            CFG_MARK_MID:   lvl_cfg.mark_mid   = val;
            CFG_MARK_HIGH:  lvl_cfg.mark_high  = val;
            CFG_RANGE_LOW:  lvl_cfg.range_low  = val;
            CFG_RANGE_HIGH: lvl_cfg.range_high = val;
            default: ;
        endcase
    endtask

    task automatic set_levels(chan_t lo, chan_t mid, chan_t hi, chan_t rlo, chan_t rhi);
        write_reg(CFG_MARK_LOW, lo);
        write_reg(CFG_MARK_MID, mid);
        write_reg(CFG_MARK_HIGH, hi);
        write_reg(CFG_RANGE_LOW, rlo);
        write_reg(CFG_RANGE_HIGH, rhi);
    endtask

    task automatic push_pixel(chan_t r, chan_t g, chan_t b);
        pending_q.push_back({b, g, r});
    endtask

    // wait until every pixel is out and the pipeline has emptied
    task automatic drain();
        while (pending_q.size() != 0 || s_tvalid || levelled_q.size() != 0)
            @(posedge aclk);
        repeat (DUT_LATENCY + 2) @(posedge aclk);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: extremes and the mid mark
        push_pixel(8'd0, 8'd128, 8'd255);
        push_pixel(8'd127, 8'd129, 8'd1);
        push_pixel(8'd254, 8'd128, 8'd0);
        push_pixel(8'd255, 8'd0, 8'd64);
        drain();

        // ordered marks, channels on and beside each mark
        set_levels(8'd50, 8'd100, 8'd200, 8'd20, 8'd230);
        push_pixel(8'd49, 8'd50, 8'd51);
        push_pixel(8'd99, 8'd100, 8'd101);
        push_pixel(8'd199, 8'd200, 8'd201);
        push_pixel(8'd0, 8'd255, 8'd150);
        drain();

        // reversed output range
        set_levels(8'd50, 8'd100, 8'd200, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd100, 8'd255);
        push_pixel(8'd75, 8'd150, 8'd230);
        drain();

        // marks out of order
        set_levels(8'd200, 8'd50, 8'd100, 8'd0, 8'd255);
        push_pixel(8'd50, 8'd30, 8'd200);
        push_pixel(8'd150, 8'd99, 8'd255);
        push_pixel(8'd10, 8'd60, 8'd120);
        drain();

        // all marks equal
        set_levels(8'd100, 8'd100, 8'd100, 8'd0, 8'd255);
        push_pixel(8'd99, 8'd100, 8'd101);
        push_pixel(8'd0, 8'd255, 8'd128);
        drain();

        // mid mark below the black point
        set_levels(8'd100, 8'd20, 8'd200, 8'd0, 8'd255);
        push_pixel(8'd20, 8'd60, 8'd150);
        push_pixel(8'd100, 8'd101, 8'd199);
        drain();

        // writes past the register list must change nothing
        write_reg(CFG_IDX_SPARE_LO, 8'd0);
        write_reg(CFG_IDX_SPARE_MID, 8'hAA);
        write_reg(CFG_IDX_SPARE_HI, 8'd255);
        push_pixel(8'd20, 8'd60, 8'd150);
        drain();

        // random phases, each with its own settings and one of four idling modes
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: set_levels(8'd0, 8'd128, 8'd255, 8'd0, 8'd255);
                1: set_levels(8'd16, 8'd100, 8'd220, 8'd10, 8'd240);
                2: set_levels(8'd200, 8'd50, 8'd100, 8'd255, 8'd0);
                3: set_levels(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                4: set_levels(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
                default: set_levels(chan_t'($urandom_range(255)),
                                    chan_t'($urandom_range(255)),
                                    chan_t'($urandom_range(255)),
                                    chan_t'($urandom_range(255)),
                                    chan_t'($urandom_range(255)));
            endcase
            case (ph % 4)
                0: begin src_idle_pct <= 0;  sink_stall_pct <= 0;  end
                1: begin src_idle_pct <= 61; sink_stall_pct <= 0;  end
                2: begin src_idle_pct <= 0;  sink_stall_pct <= 61; end
                default: begin src_idle_pct <= 10; sink_stall_pct <= 10; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_pixel(pick_channel(), pick_channel(), pick_channel());
            drain();
        end

        // receiver holds off while the source keeps offering
        set_levels(8'd30, 8'd90, 8'd210, 8'd5, 8'd250);
        src_idle_pct   <= 0;
        sink_stall_pct <= 0;
        hold_arm       <= 1'b1;
        for (int n = 0; n < PRESSURE_ITEMS; n++)
            push_pixel(pick_channel(), pick_channel(), pick_channel());
        while (!hold_done)
            @(posedge aclk);
        drain();

        repeat (2 * DUT_LATENCY) @(posedge aclk);
        if (err_cnt == 0 && levelled_q.size() == 0) begin
            $display("rgb_levels_adjust test passed");
        end else begin
            $display("rgb_levels_adjust test failed");
        end
        $finish;
    end

endmodule
